// File: sv/signed_radix_to_symbols_top_macros.svh
// ----------------------------------------------------------------------------
// signed_radix_to_symbols_top_macros.svh
// Assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef SIGNED_RADIX_TO_SYMBOLS_TOP_MACROS_SVH
`define SIGNED_RADIX_TO_SYMBOLS_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define SRTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define SRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/srts_pkg.sv
// ----------------------------------------------------------------------------
// srts_pkg
// Types and constants of the signed radix to symbols converter.
// ----------------------------------------------------------------------------
`default_nettype none

package srts_pkg;

  localparam int ValueW   = 32;
  localparam int CharW    = 8;
  localparam int CountW   = 5;
  localparam int CfgW     = 64;
  localparam int SymSlots = 16;
  localparam int MaxRadix = 16;
  localparam int RadixCap = (MaxRadix < SymSlots) ? MaxRadix : SymSlots;
  localparam int SymW     = SymSlots * CharW;

  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;

  localparam logic [CountW-1:0] CountRst = 5'd10;
  localparam logic [CfgW-1:0]   SymLoRst = 64'h3736353433323130;
  localparam logic [CfgW-1:0]   SymHiRst = 64'h0000000000003938;

  typedef enum logic [1:0] {
    CFG_SYMBOL_COUNT = 2'd0,
    CFG_SYMBOLS_LOW  = 2'd1,
    CFG_SYMBOLS_HIGH = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic              neg;
    logic [ValueW-1:0] mag;
    logic [CountW-1:0] radix;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

// File: sv/srts_fifo.sv
// ----------------------------------------------------------------------------
// srts_fifo
// Two-entry queue between the classifying front and the digit back end.
// ----------------------------------------------------------------------------
`default_nettype none

module srts_fifo
  import srts_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire item_t   push_item,
  input  wire logic    pop,
  output item_t        head,
  output q_stat_t      stat
);

  item_t      entries_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

  assign head       = entries_r[rd_ptr_r];
  assign stat.empty = (count_r == 2'd0);
  assign stat.full  = (count_r == 2'd2);

endmodule

`default_nettype wire

// File: sv/srts_front.sv
// ----------------------------------------------------------------------------
// srts_front
// Configuration registers, alphabet check, sign split of accepted values.
// ----------------------------------------------------------------------------
`default_nettype none

module srts_front
  import srts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CfgW-1:0]   cfg_wdata,
  input  wire logic              accept,
  input  wire logic [ValueW-1:0] in_value,
  output logic                   push,
  output item_t                  push_item,
  output logic [SymW-1:0]        syms
);

  logic [CountW-1:0] count_r;
  logic [CfgW-1:0]   sym_lo_r;
  logic [CfgW-1:0]   sym_hi_r;
  logic [CountW-1:0] radix;

  function automatic logic [CountW-1:0] usable_radix(input logic [CountW-1:0] count,
                                                      input logic [SymW-1:0]   s);
    logic [CountW-1:0] lim;
    logic [CountW-1:0] n;
    logic              bad;
    lim = (count > CountW'(RadixCap)) ? CountW'(RadixCap) : count;
    n   = lim;
    bad = 1'b0;
    for (int i = SymSlots - 1; i >= 0; i--) begin
      if (CountW'(i) < lim && s[i*CharW +: CharW] == '0) begin
        n = CountW'(i);
      end
    end
    for (int i = 0; i < SymSlots; i++) begin
      if (CountW'(i) < n) begin
        if (s[i*CharW +: CharW] == ChPlus || s[i*CharW +: CharW] == ChMinus) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < SymSlots; j++) begin
          if (CountW'(j) < n && s[j*CharW +: CharW] == s[i*CharW +: CharW]) begin
            bad = 1'b1;
          end
        end
      end
    end
    return (bad || n < CountW'(2)) ? '0 : n;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= CountRst;
      sym_lo_r <= SymLoRst;
      sym_hi_r <= SymHiRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYMBOL_COUNT: count_r  <= cfg_wdata[CountW-1:0];
        CFG_SYMBOLS_LOW:  sym_lo_r <= cfg_wdata;
        CFG_SYMBOLS_HIGH: sym_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign syms  = {sym_hi_r, sym_lo_r};
  assign radix = usable_radix(count_r, syms);

  // bad alphabet: value dropped, nothing emitted
  assign push            = accept && (radix != '0);
  assign push_item.neg   = in_value[ValueW-1];
  assign push_item.mag   = in_value[ValueW-1] ? (ValueW'(0) - in_value) : in_value;
  assign push_item.radix = radix;

endmodule

`default_nettype wire

// File: sv/srts_back.sv
// ----------------------------------------------------------------------------
// srts_back
// Digit engine: byte-wise division into a digit stack, then symbol output.
// ----------------------------------------------------------------------------
`default_nettype none

module srts_back
  import srts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire q_stat_t           q_stat,
  input  wire item_t             head,
  input  wire logic [SymW-1:0]   syms,
  output logic                   pop,
  output logic                   out_valid,
  output logic [CharW-1:0]       out_char_out,
  output logic                   out_last
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SIGN, S_EMIT} state_t;

  state_t            state_r,  state_nxt;
  logic [ValueW-1:0] mag_r,    mag_nxt;
  logic [ValueW-1:0] quo_r,    quo_nxt;
  logic [3:0]        rem_r,    rem_nxt;
  logic [1:0]        bsel_r,   bsel_nxt;
  logic [CountW-1:0] radix_r,  radix_nxt;
  logic              neg_r,    neg_nxt;
  logic [5:0]        cnt_r,    cnt_nxt;
  logic [3:0]        digits_r [32];
  logic              out_valid_r, out_valid_nxt;
  logic [CharW-1:0]  out_char_r,  out_char_nxt;
  logic              out_last_r,  out_last_nxt;
  logic              dpush;
  logic [11:0]       step;
  logic [ValueW-1:0] quo_full;
  logic [5:0]        cnt_dec;
  logic [3:0]        top_digit;

  // eight restoring steps on one dividend byte: {quotient byte, remainder}
  function automatic logic [11:0] div_byte(input logic [3:0] rem, input logic [7:0] b,
                                           input logic [CountW-1:0] rdx);
    logic [4:0] r;
    logic [3:0] rr;
    logic [7:0] qb;
    rr = rem;
    qb = '0;
    for (int k = 7; k >= 0; k--) begin
      r = {rr, b[k]};
      if (r >= rdx) begin
        r     = r - rdx;
        qb[k] = 1'b1;
      end
      rr = r[3:0];
    end
    return {qb, rr};
  endfunction

  function automatic logic [1:0] top_byte(input logic [ValueW-1:0] x);
    priority if (x[31:24] != '0) return 2'd3;
    else if (x[23:16] != '0) return 2'd2;
    else if (x[15:8] != '0) return 2'd1;
    else return 2'd0;
  endfunction

  assign step      = div_byte(rem_r, mag_r[{bsel_r, 3'b000} +: 8], radix_r);
  assign quo_full  = {quo_r[ValueW-9:0], step[11:4]};
  assign cnt_dec   = cnt_r - 6'd1;
  assign top_digit = digits_r[cnt_dec[4:0]];

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    bsel_nxt      = bsel_r;
    radix_nxt     = radix_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = 1'b0;
    pop           = 1'b0;
    dpush         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          mag_nxt   = head.mag;
          neg_nxt   = head.neg;
          radix_nxt = head.radix;
          quo_nxt   = '0;
          rem_nxt   = '0;
          bsel_nxt  = top_byte(head.mag);
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (bsel_r == 2'd0) begin
          dpush   = 1'b1;
          cnt_nxt = cnt_r + 6'd1;
          if (quo_full == '0) begin
            state_nxt = neg_r ? S_SIGN : S_EMIT;
          end else begin
            mag_nxt  = quo_full;
            quo_nxt  = '0;
            rem_nxt  = '0;
            bsel_nxt = top_byte(quo_full);
          end
        end else begin
          bsel_nxt = bsel_r - 2'd1;
          quo_nxt  = quo_full;
          rem_nxt  = step[3:0];
        end
      end
      S_SIGN: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = ChMinus;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = syms[{top_digit, 3'b000} +: CharW];
        out_last_nxt  = (cnt_r == 6'd1);
        cnt_nxt       = cnt_dec;
        if (cnt_r == 6'd1) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
    mag_r      <= mag_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    bsel_r     <= bsel_nxt;
    radix_r    <= radix_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    if (dpush) begin
      digits_r[cnt_r[4:0]] <= step[3:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_last     = out_last_r;

endmodule

`default_nettype wire

// File: sv/signed_radix_to_symbols_top.sv
// ----------------------------------------------------------------------------
// signed_radix_to_symbols_top
// Signed 32-bit integer to text in a configurable radix and alphabet.
// ----------------------------------------------------------------------------
// A value is taken when start is high and busy is low; busy rises only when
// two accepted values are queued behind the one being converted. Each output
// byte is shown for one cycle with out_valid, sign first, most significant
// digit next, out_last on the final byte; the receiver cannot stall it. A
// value passes the queue hand-off, then for each digit the divider takes in
// turn each byte of the remaining quotient up to its highest nonzero byte
// (1 to 4), then each output byte passes the output register; the longest
// conversion is that of -2147483648 in radix 2, set by the byte-wise divider.
// Values arriving while the alphabet is invalid are dropped without output.
`default_nettype none

`include "signed_radix_to_symbols_top_macros.svh"

module signed_radix_to_symbols_top
  import srts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CfgW-1:0]   cfg_wdata,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [ValueW-1:0] in_value,
  output logic                   out_valid,
  output logic [CharW-1:0]       out_char_out,
  output logic                   out_last
);

  logic            accept;
  logic            push;
  item_t           push_item;
  item_t           head;
  logic            pop;
  q_stat_t         q_stat;
  logic [SymW-1:0] syms;

  assign busy   = q_stat.full;
  assign accept = start && !busy;

  srts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_value  (in_value),
    .push      (push),
    .push_item (push_item),
    .syms      (syms)
  );

  srts_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  srts_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .head         (head),
    .syms         (syms),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_char_out (out_char_out),
    .out_last     (out_last)
  );

  `SRTS_ASSERT_NEXT(a_gap_after_last, out_valid && out_last, !out_valid, "no gap after last beat")
  `SRTS_ASSERT_NOW(a_sign_not_last, out_valid && out_char_out == ChMinus, !out_last, "sign ends run")
  `SRTS_ASSERT_NOW(a_sign_first, out_valid && out_char_out == ChMinus, !$past(out_valid), "sign not first")
  `SRTS_ASSERT_NOW(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")

endmodule

`default_nettype wire
